@@ src/srsc_pkg.sv @@
// Sonar ray scan converter package: field widths, channel payload types,
// controller command and status types, sine constants and the jet colour functions.
// No dependencies.
package srsc_pkg;

  localparam int ANG_W = 16;
  localparam int IDX_W = 11;
  localparam int CNT_W = 12;
  localparam int RNG_W = 16;
  localparam int INT_W = 8;
  localparam int PPM_W = 16;
  localparam int PIX_W = 9;
  localparam int COL_W = 8;

  localparam int DEF_IMAGE_SIZE  = 512;
  localparam int DEF_MAX_SAMPLES = 2048;

  localparam logic [PPM_W-1:0] PPM_RESET   = 16'd6400;
  localparam logic [RNG_W-1:0] RANGE_RESET = 16'd2560;

  // quarter-wave sine datapath widths
  localparam int Z_W    = 15;
  localparam int Z2_W   = 15;
  localparam int U_W    = 16;
  localparam int V_W    = 17;
  localparam int TRIG_W = 15;

  localparam logic [Z_W-1:0]    QUARTER_TURN = 15'd16384;
  localparam logic [12:0]       SIN_C1       = 13'd4639;
  localparam logic [U_W-1:0]    SIN_C2       = 16'd42047;
  localparam logic [V_W-1:0]    SIN_C3       = 17'd102944;
  localparam logic [TRIG_W-1:0] SIN_MAX      = 15'h7FFF;

  // scaling and rounding widths
  localparam int PIR_W  = IDX_W + RNG_W;
  localparam int SCL_W  = TRIG_W + PPM_W;
  localparam int PROD_W = PIR_W + SCL_W;
  localparam int FRAC_SHIFT = 30;
  localparam int QM_W   = PROD_W - FRAC_SHIFT + 1;
  localparam int N_W    = QM_W + 2;
  localparam int DEN_W  = CNT_W + 1;

  typedef struct packed {
    logic [ANG_W-1:0] ray_angle;
    logic [IDX_W-1:0] sample_index;
    logic [CNT_W-1:0] sample_count;
    logic [RNG_W-1:0] ray_range;
    logic [INT_W-1:0] intensity;
  } sample_t;

  typedef struct packed {
    logic             pixel_valid;
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
    logic [COL_W-1:0] red;
    logic [COL_W-1:0] green;
    logic [COL_W-1:0] blue;
    logic             clear_image;
  } pixel_t;

  typedef struct packed {
    logic load;
    logic sin1;
    logic sin2;
    logic sin3;
    logic sin4;
    logic scale;
    logic prod;
    logic prep1;
    logic prep2;
    logic div_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } st_t;

  function automatic logic [COL_W-1:0] jet_channel(logic [INT_W-1:0] idx, int k);
    int d;
    int v;
    d = 4 * int'(idx) - k;
    if (d < 0) d = -d;
    v = 382 - d;
    if (v < 0) return '0;
    if (v > 255) return '1;
    return COL_W'(v);
  endfunction

  function automatic logic [3*COL_W-1:0] jet_colour(logic [INT_W-1:0] idx);
    return {jet_channel(idx, 765), jet_channel(idx, 510), jet_channel(idx, 255)};
  endfunction

endpackage

@@ src/srsc_if.sv @@
// Channel interfaces of the sonar ray scan converter: sample requests,
// pixel write requests and the scale register write. Depends on srsc_pkg.
interface srsc_sample_if import srsc_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface srsc_pixel_if import srsc_pkg::*; ();
  logic   valid;
  logic   ready;
  pixel_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface srsc_cfg_if import srsc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PPM_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ src/srsc_ctrl.sv @@
// Sequencing state machine of the sonar ray scan converter.
// Steps the datapath through sine, scaling, rounding and division. Depends on srsc_pkg.
module srsc_ctrl import srsc_pkg::*; #(
  parameter int IMAGE_SIZE = DEF_IMAGE_SIZE
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic sample_valid_i,
  output logic sample_ready_o,
  input  st_t  st_i,
  output cmd_t cmd_o
);

  localparam int QW   = $clog2(IMAGE_SIZE);
  localparam int DC_W = $clog2(QW);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_SIN1  = 11'b000_0000_0010,
    S_SIN2  = 11'b000_0000_0100,
    S_SIN3  = 11'b000_0000_1000,
    S_SIN4  = 11'b000_0001_0000,
    S_SCALE = 11'b000_0010_0000,
    S_PROD  = 11'b000_0100_0000,
    S_PREP1 = 11'b000_1000_0000,
    S_PREP2 = 11'b001_0000_0000,
    S_DIV   = 11'b010_0000_0000,
    S_EMIT  = 11'b100_0000_0000
  } state_e;

  state_e            state_q, state_d;
  logic [DC_W-1:0]   div_cnt_q, div_cnt_d;

  assign sample_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = (state_q == S_IDLE) && sample_valid_i;
    cmd_o.sin1     = (state_q == S_SIN1);
    cmd_o.sin2     = (state_q == S_SIN2);
    cmd_o.sin3     = (state_q == S_SIN3);
    cmd_o.sin4     = (state_q == S_SIN4);
    cmd_o.scale    = (state_q == S_SCALE);
    cmd_o.prod     = (state_q == S_PROD);
    cmd_o.prep1    = (state_q == S_PREP1);
    cmd_o.prep2    = (state_q == S_PREP2);
    cmd_o.div_step = (state_q == S_DIV);
    cmd_o.emit     = (state_q == S_EMIT) && st_i.out_free;
  end

  always_comb begin
    state_d   = state_q;
    div_cnt_d = div_cnt_q;
    case (state_q)
      S_IDLE: begin
        if (sample_valid_i) state_d = S_SIN1;
      end
      S_SIN1:  state_d = S_SIN2;
      S_SIN2:  state_d = S_SIN3;
      S_SIN3:  state_d = S_SIN4;
      S_SIN4:  state_d = S_SCALE;
      S_SCALE: state_d = S_PROD;
      S_PROD:  state_d = S_PREP1;
      S_PREP1: state_d = S_PREP2;
      S_PREP2: begin
        div_cnt_d = DC_W'(QW - 1);
        state_d   = S_DIV;
      end
      S_DIV: begin
        if (div_cnt_q == '0) begin
          state_d = S_EMIT;
        end else begin
          div_cnt_d = div_cnt_q - 1'b1;
        end
      end
      S_EMIT: begin
        if (st_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      div_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      div_cnt_q <= div_cnt_d;
    end
  end

`ifndef ASSERT_OFF
  a_accept_to_prep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sample_valid_i && sample_ready_o) |-> ##8 (state_q == S_PREP2))
    else $error("request did not reach rounding stage in eight cycles");

  a_div_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PREP2) |-> ##(QW+1) (state_q == S_EMIT))
    else $error("divider loop length wrong");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |=> (state_q == S_IDLE))
    else $error("emit did not return to idle");
`endif

endmodule

@@ src/srsc_datapath.sv @@
// Datapath of the sonar ray scan converter: sine lanes, scaling multipliers,
// rounding, shared-divisor restoring dividers and the output register. Depends on srsc_pkg.
module srsc_datapath import srsc_pkg::*; #(
  parameter int IMAGE_SIZE  = DEF_IMAGE_SIZE,
  parameter int MAX_SAMPLES = DEF_MAX_SAMPLES
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sample_t           sample_data_i,
  input  cmd_t              cmd_i,
  output st_t               st_o,
  srsc_cfg_if.sink          cfg_i,
  srsc_pixel_if.source      pixel_o
);

  localparam int QW    = $clog2(IMAGE_SIZE);
  localparam int REM_W = DEN_W + QW;
  localparam int CRD_W = QW + 2;

  logic [PPM_W-1:0] ppm_q;
  logic [RNG_W-1:0] last_range_q;
  logic [ANG_W-1:0] angle_q;
  logic [IDX_W-1:0] idx_q;
  logic [CNT_W-1:0] cnt_q;
  logic [RNG_W-1:0] rng_q;
  logic [INT_W-1:0] inten_q;
  logic             ok_q;
  logic             clear_q;

  logic [Z_W-1:0]    z      [2];
  logic [Z2_W-1:0]   z2_q   [2];
  logic [U_W-1:0]    u_q    [2];
  logic [V_W-1:0]    v_q    [2];
  logic [TRIG_W-1:0] s_q    [2];
  logic [SCL_W-1:0]  scl_q  [2];
  logic [PIR_W-1:0]  pir_q;
  logic [PROD_W-1:0] prod_q [2];
  logic              neg_q  [2];
  logic [N_W-1:0]    n_q    [2];
  logic              nneg_q [2];
  logic              oor_q  [2];
  logic [REM_W-1:0]  rem_q  [2];
  logic [QW-1:0]     quo_q  [2];
  logic [REM_W-1:0]  dsh_q;

  pixel_t out_q;
  logic   out_valid_q;

  logic [1:0]       quad;
  logic [DEN_W-1:0] den;
  logic             lane_ok [2];
  logic             pix_ok;
  logic [CRD_W-1:0] coord   [2];
  logic [3*COL_W-1:0] colour;

  assign quad = angle_q[ANG_W-1:ANG_W-2];
  assign z[0] = {1'b0, angle_q[ANG_W-3:0]};
  assign z[1] = QUARTER_TURN - z[0];
  assign den  = {cnt_q, 1'b0};

  assign cfg_i.ready   = 1'b1;
  assign pixel_o.valid = out_valid_q;
  assign pixel_o.data  = out_q;
  assign st_o.out_free = !out_valid_q || pixel_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ppm_q        <= PPM_RESET;
      last_range_q <= RANGE_RESET;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_i.valid) ppm_q <= cfg_i.data;
      if (cmd_i.load) last_range_q <= sample_data_i.ray_range;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (pixel_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // latch request and screen count, index and range
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      angle_q <= sample_data_i.ray_angle;
      idx_q   <= sample_data_i.sample_index;
      cnt_q   <= sample_data_i.sample_count;
      rng_q   <= sample_data_i.ray_range;
      inten_q <= sample_data_i.intensity;
      clear_q <= (sample_data_i.ray_range != last_range_q);
      ok_q    <= (sample_data_i.ray_range != '0) && (sample_data_i.sample_count != '0) &&
                 (32'(sample_data_i.sample_count) <= 32'(MAX_SAMPLES)) &&
                 (CNT_W'(sample_data_i.sample_index) < sample_data_i.sample_count);
    end
  end

  // sine lanes: lane 0 on f, lane 1 on the complement
  always_ff @(posedge clk_i) begin
    logic [2*Z_W-1:0]  p1;
    logic [27:0]       p2;
    logic [30:0]       p3;
    logic [31:0]       p4;
    logic [V_W-1:0]    w;
    for (int k = 0; k < 2; k++) begin
      p1 = (2*Z_W)'(z[k]) * (2*Z_W)'(z[k]);
      p2 = 28'(SIN_C1) * 28'(z2_q[k]);
      p3 = 31'(u_q[k]) * 31'(z2_q[k]);
      p4 = 32'(v_q[k]) * 32'(z[k]);
      w  = V_W'(p4 >> 15);
      if (cmd_i.sin1) z2_q[k] <= Z2_W'(p1 >> 14);
      if (cmd_i.sin2) u_q[k]  <= SIN_C2 - U_W'(p2 >> 14);
      if (cmd_i.sin3) v_q[k]  <= SIN_C3 - V_W'(p3 >> 14);
      if (cmd_i.sin4) s_q[k]  <= (w > V_W'(SIN_MAX)) ? SIN_MAX : TRIG_W'(w);
    end
  end

  // scale: lane 0 is x (cosine), lane 1 is y (negated sine)
  always_ff @(posedge clk_i) begin
    logic [TRIG_W-1:0] mag_x;
    logic [TRIG_W-1:0] mag_y;
    mag_x = quad[0] ? s_q[0] : s_q[1];
    mag_y = quad[0] ? s_q[1] : s_q[0];
    if (cmd_i.scale) begin
      scl_q[0] <= SCL_W'(mag_x) * SCL_W'(ppm_q);
      scl_q[1] <= SCL_W'(mag_y) * SCL_W'(ppm_q);
      neg_q[0] <= quad[1] ^ quad[0];
      neg_q[1] <= ~quad[1];
      pir_q    <= PIR_W'(idx_q) * PIR_W'(rng_q);
    end
  end

  // product, rounding shift, divider setup and iteration
  always_ff @(posedge clk_i) begin
    logic [PROD_W:0]  rnd;
    logic [QM_W-1:0]  qm;
    logic [N_W-1:0]   an;
    for (int k = 0; k < 2; k++) begin
      rnd = {1'b0, prod_q[k]} +
            (neg_q[k] ? (PROD_W+1)'({FRAC_SHIFT{1'b1}}) : '0);
      qm  = rnd[PROD_W:FRAC_SHIFT];
      an  = n_q[k][N_W-1] ? (N_W'(0) - n_q[k]) : n_q[k];
      if (cmd_i.prod) prod_q[k] <= PROD_W'(pir_q) * PROD_W'(scl_q[k]);
      if (cmd_i.prep1) begin
        n_q[k] <= neg_q[k] ? (N_W'(cnt_q) - N_W'(qm)) : (N_W'(cnt_q) + N_W'(qm));
      end
      if (cmd_i.prep2) begin
        nneg_q[k] <= n_q[k][N_W-1];
        oor_q[k]  <= an >= (N_W'(den) << QW);
        rem_q[k]  <= REM_W'(an);
        quo_q[k]  <= '0;
      end else if (cmd_i.div_step) begin
        if (rem_q[k] >= dsh_q) begin
          rem_q[k] <= rem_q[k] - dsh_q;
          quo_q[k] <= {quo_q[k][QW-2:0], 1'b1};
        end else begin
          quo_q[k] <= {quo_q[k][QW-2:0], 1'b0};
        end
      end
    end
    if (cmd_i.prep2) begin
      dsh_q <= REM_W'(den) << (QW - 1);
    end else if (cmd_i.div_step) begin
      dsh_q <= dsh_q >> 1;
    end
  end

  always_comb begin
    logic [CRD_W-1:0] mag;
    logic [CRD_W-1:0] off;
    for (int k = 0; k < 2; k++) begin
      mag        = CRD_W'(quo_q[k]) + CRD_W'(rem_q[k] != '0);
      off        = nneg_q[k] ? (CRD_W'(0) - mag) : CRD_W'(quo_q[k]);
      coord[k]   = CRD_W'(IMAGE_SIZE / 2) + off;
      lane_ok[k] = !oor_q[k] && !coord[k][CRD_W-1] &&
                   (coord[k][CRD_W-2:0] < (CRD_W-1)'(IMAGE_SIZE));
    end
  end

  assign pix_ok = ok_q && lane_ok[0] && lane_ok[1];
  assign colour = jet_colour(inten_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q.pixel_valid <= pix_ok;
      out_q.pixel_x     <= pix_ok ? PIX_W'($unsigned(coord[0])) : '0;
      out_q.pixel_y     <= pix_ok ? PIX_W'($unsigned(coord[1])) : '0;
      out_q.red         <= pix_ok ? colour[3*COL_W-1:2*COL_W] : '0;
      out_q.green       <= pix_ok ? colour[2*COL_W-1:COL_W] : '0;
      out_q.blue        <= pix_ok ? colour[COL_W-1:0] : '0;
      out_q.clear_image <= clear_q;
    end
  end

endmodule

@@ src/sonar_ray_scan_converter_top.sv @@
// Sonar ray scan converter top level: one sample request in, one pixel write out.
// The pixel write is registered in the emit state, after the sine, scaling, product,
// rounding and division steps; a new sample is taken only once the last one has been
// emitted, emit waits while the output register is still full, and the divider loop yields one bit per cycle.
// Reset: asynchronous; scale returns to 6400, stored range to 2560, no pixel pending.
// Depends on srsc_pkg, srsc_if, srsc_ctrl and srsc_datapath.
module sonar_ray_scan_converter_top import srsc_pkg::*; #(
  parameter int IMAGE_SIZE  = DEF_IMAGE_SIZE,
  parameter int MAX_SAMPLES = DEF_MAX_SAMPLES
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  srsc_sample_if.sink  sample_i,
  srsc_cfg_if.sink     cfg_i,
  srsc_pixel_if.source pixel_o
);

  cmd_t cmd;
  st_t  st;

  srsc_ctrl #(
    .IMAGE_SIZE (IMAGE_SIZE)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sample_valid_i (sample_i.valid),
    .sample_ready_o (sample_i.ready),
    .st_i           (st),
    .cmd_o          (cmd)
  );

  srsc_datapath #(
    .IMAGE_SIZE  (IMAGE_SIZE),
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .sample_data_i (sample_i.data),
    .cmd_i         (cmd),
    .st_o          (st),
    .cfg_i         (cfg_i),
    .pixel_o       (pixel_o)
  );

endmodule
